### hw/rtl/md2_pkg.sv
// md2_pkg: shared types, mode codes and the md2 substitution table
// used by md2_compress, md2_hash_engine and md2_chk; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package md2_pkg;

  localparam logic [1:0] MODE_ABSORB   = 2'd0;
  localparam logic [1:0] MODE_FINISH   = 2'd1;
  localparam logic [1:0] MODE_FIN_ONLY = 2'd2;

  localparam int unsigned BLOCK_BYTES = 16;

  typedef logic [BLOCK_BYTES-1:0][7:0] md2_block_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] mode;
  } md2_in_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } md2_out_t;

  typedef struct packed {
    logic start;
    logic use_sum;
    logic upd_sum;
    logic clear;
  } md2_ctrl_t;

  typedef struct packed {
    logic       done;
    md2_block_t chain;
  } md2_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h29, 8'h2E, 8'h43, 8'hC9, 8'hA2, 8'hD8, 8'h7C, 8'h01,
    8'h3D, 8'h36, 8'h54, 8'hA1, 8'hEC, 8'hF0, 8'h06, 8'h13,
    8'h62, 8'hA7, 8'h05, 8'hF3, 8'hC0, 8'hC7, 8'h73, 8'h8C,
    8'h98, 8'h93, 8'h2B, 8'hD9, 8'hBC, 8'h4C, 8'h82, 8'hCA,
    8'h1E, 8'h9B, 8'h57, 8'h3C, 8'hFD, 8'hD4, 8'hE0, 8'h16,
    8'h67, 8'h42, 8'h6F, 8'h18, 8'h8A, 8'h17, 8'hE5, 8'h12,
    8'hBE, 8'h4E, 8'hC4, 8'hD6, 8'hDA, 8'h9E, 8'hDE, 8'h49,
    8'hA0, 8'hFB, 8'hF5, 8'h8E, 8'hBB, 8'h2F, 8'hEE, 8'h7A,
    8'hA9, 8'h68, 8'h79, 8'h91, 8'h15, 8'hB2, 8'h07, 8'h3F,
    8'h94, 8'hC2, 8'h10, 8'h89, 8'h0B, 8'h22, 8'h5F, 8'h21,
    8'h80, 8'h7F, 8'h5D, 8'h9A, 8'h5A, 8'h90, 8'h32, 8'h27,
    8'h35, 8'h3E, 8'hCC, 8'hE7, 8'hBF, 8'hF7, 8'h97, 8'h03,
    8'hFF, 8'h19, 8'h30, 8'hB3, 8'h48, 8'hA5, 8'hB5, 8'hD1,
    8'hD7, 8'h5E, 8'h92, 8'h2A, 8'hAC, 8'h56, 8'hAA, 8'hC6,
    8'h4F, 8'hB8, 8'h38, 8'hD2, 8'h96, 8'hA4, 8'h7D, 8'hB6,
    8'h76, 8'hFC, 8'h6B, 8'hE2, 8'h9C, 8'h74, 8'h04, 8'hF1,
    8'h45, 8'h9D, 8'h70, 8'h59, 8'h64, 8'h71, 8'h87, 8'h20,
    8'h86, 8'h5B, 8'hCF, 8'h65, 8'hE6, 8'h2D, 8'hA8, 8'h02,
    8'h1B, 8'h60, 8'h25, 8'hAD, 8'hAE, 8'hB0, 8'hB9, 8'hF6,
    8'h1C, 8'h46, 8'h61, 8'h69, 8'h34, 8'h40, 8'h7E, 8'h0F,
    8'h55, 8'h47, 8'hA3, 8'h23, 8'hDD, 8'h51, 8'hAF, 8'h3A,
    8'hC3, 8'h5C, 8'hF9, 8'hCE, 8'hBA, 8'hC5, 8'hEA, 8'h26,
    8'h2C, 8'h53, 8'h0D, 8'h6E, 8'h85, 8'h28, 8'h84, 8'h09,
    8'hD3, 8'hDF, 8'hCD, 8'hF4, 8'h41, 8'h81, 8'h4D, 8'h52,
    8'h6A, 8'hDC, 8'h37, 8'hC8, 8'h6C, 8'hC1, 8'hAB, 8'hFA,
    8'h24, 8'hE1, 8'h7B, 8'h08, 8'h0C, 8'hBD, 8'hB1, 8'h4A,
    8'h78, 8'h88, 8'h95, 8'h8B, 8'hE3, 8'h63, 8'hE8, 8'h6D,
    8'hE9, 8'hCB, 8'hD5, 8'hFE, 8'h3B, 8'h00, 8'h1D, 8'h39,
    8'hF2, 8'hEF, 8'hB7, 8'h0E, 8'h66, 8'h58, 8'hD0, 8'hE4,
    8'hA6, 8'h77, 8'h72, 8'hF8, 8'hEB, 8'h75, 8'h4B, 8'h0A,
    8'h31, 8'h44, 8'h50, 8'hB4, 8'h8F, 8'hED, 8'h1F, 8'h1A,
    8'hDB, 8'h99, 8'h8D, 8'h33, 8'h9F, 8'h11, 8'h83, 8'h14
  };

  function automatic logic [7:0] md2_sbox(input logic [7:0] x);
    return SBOX[x];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/md2_compress.sv
// md2_compress: one shared s-box lookup per cycle over a rotating 48-byte work
// register, 18 rounds, then 16 checksum steps if upd_sum is set; holds chaining
// state and checksum; depends on md2_pkg
`timescale 1ns / 1ps
`default_nettype none

module md2_compress (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  md2_pkg::md2_ctrl_t  ctrl_i,
  input  md2_pkg::md2_block_t blk_i,
  output md2_pkg::md2_stat_t  stat_o
);
  import md2_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_CKSUM
  } cstate_e;

  cstate_e          state_q;
  logic [5:0]       k_q;
  logic [4:0]       r_q;
  logic [7:0]       t_q;
  logic [47:0][7:0] work_q;
  md2_block_t       blk_q;
  md2_block_t       chain_q;
  md2_block_t       sum_q;
  logic             upd_q;
  logic             done_q;

  logic [7:0]       sidx;
  logic [7:0]       sval;
  logic [7:0]       w_new;
  logic [7:0]       c_new;
  logic [47:0][7:0] work_rot;
  md2_block_t       sum_rot;
  md2_block_t       blk_rot;
  md2_block_t       src;

  // shared s-box unit
  assign sidx     = (state_q == C_CKSUM) ? (blk_q[0] ^ t_q) : t_q;
  assign sval     = md2_sbox(sidx);
  assign w_new    = work_q[0] ^ sval;
  assign c_new    = sum_q[0] ^ sval;
  assign work_rot = {w_new, work_q[47:1]};
  assign sum_rot  = {c_new, sum_q[15:1]};
  assign blk_rot  = {blk_q[0], blk_q[15:1]};
  assign src      = ctrl_i.use_sum ? sum_q : blk_i;

  assign stat_o.done  = done_q;
  assign stat_o.chain = chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      k_q     <= '0;
      r_q     <= '0;
      t_q     <= '0;
      work_q  <= '0;
      blk_q   <= '0;
      chain_q <= '0;
      sum_q   <= '0;
      upd_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        chain_q <= '0;
        sum_q   <= '0;
      end
      case (state_q)
        C_IDLE: begin
          done_q <= 1'b0;
          if (ctrl_i.start) begin
            work_q  <= {chain_q ^ src, src, chain_q};
            blk_q   <= src;
            t_q     <= '0;
            k_q     <= '0;
            r_q     <= '0;
            upd_q   <= ctrl_i.upd_sum;
            state_q <= C_ROUND;
          end
        end
        C_ROUND: begin
          work_q <= work_rot;
          done_q <= (k_q == 6'd47) && (r_q == 5'd17) && !upd_q;
          if (k_q == 6'd47) begin
            k_q <= '0;
            r_q <= r_q + 5'd1;
            if (r_q == 5'd17) begin
              chain_q <= work_rot[15:0];
              t_q     <= sum_q[15];
              state_q <= upd_q ? C_CKSUM : C_IDLE;
            end else begin
              t_q <= w_new + {3'b000, r_q};
            end
          end else begin
            k_q <= k_q + 6'd1;
            t_q <= w_new;
          end
        end
        C_CKSUM: begin
          sum_q  <= sum_rot;
          blk_q  <= blk_rot;
          t_q    <= c_new;
          done_q <= (k_q == 6'd15);
          if (k_q == 6'd15) begin
            state_q <= C_IDLE;
          end else begin
            k_q <= k_q + 6'd1;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= C_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/md2_hash_engine.sv
// md2_hash_engine: absorbs one byte per beat, fills a 16-byte block and drives
// md2_compress per block, padding and the final checksum block; uses md2_pkg
// a fin-only beat absorbs no byte; an absorb beat that leaves the block open keeps
// ready high; a full block runs 48 s-box steps x 18 rounds + 16 checksum steps,
// one lookup per cycle; a finishing beat compresses the padded and checksum blocks
// ready is low while a compression runs; the digest sits in an output register
// async active-low reset clears chain, checksum and count; a digest restarts them
`timescale 1ns / 1ps
`default_nettype none

module md2_hash_engine (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  md2_pkg::md2_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output md2_pkg::md2_out_t  out_data_o
);
  import md2_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_BLK_START,
    S_BLK_WAIT,
    S_SUM_START,
    S_SUM_WAIT,
    S_EMIT
  } state_e;

  state_e     state_q;
  md2_block_t buf_q;
  logic [3:0] cnt_q;
  logic       fin_q;
  logic       padded_q;
  logic       out_valid_q;
  md2_out_t   out_q;

  md2_ctrl_t  ctrl;
  md2_stat_t  stat;
  logic       accept;
  logic       absorb;
  logic       finish;
  logic       emit;
  logic [7:0] pad;
  md2_out_t   digest;

  assign accept = in_valid_i && in_ready_o;
  assign absorb = (in_data_i.mode == MODE_ABSORB) || (in_data_i.mode == MODE_FINISH);
  assign finish = (in_data_i.mode != MODE_ABSORB);
  assign emit   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign pad    = 8'(5'd16 - {1'b0, cnt_q});

  assign ctrl.start   = (state_q == S_BLK_START) || (state_q == S_SUM_START);
  assign ctrl.use_sum = (state_q == S_SUM_START);
  assign ctrl.upd_sum = (state_q == S_BLK_START);
  assign ctrl.clear   = emit;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      digest.digest_high[63-8*k -: 8] = stat.chain[k];
      digest.digest_low[63-8*k -: 8]  = stat.chain[k+8];
    end
  end

  md2_compress u_compress (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .blk_i  (buf_q),
    .stat_o (stat)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      buf_q       <= '0;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      padded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            fin_q <= finish;
            if (absorb) begin
              buf_q[cnt_q] <= in_data_i.data_byte;
              cnt_q        <= cnt_q + 4'd1;
            end
            if (absorb && (cnt_q == 4'd15)) begin
              state_q <= S_BLK_START;
            end else if (finish) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          for (int k = 0; k < BLOCK_BYTES; k++) begin
            if (4'(k) >= cnt_q) begin
              buf_q[k] <= pad;
            end
          end
          padded_q <= 1'b1;
          cnt_q    <= '0;
          state_q  <= S_BLK_START;
        end
        S_BLK_START: state_q <= S_BLK_WAIT;
        S_BLK_WAIT: begin
          if (stat.done) begin
            if (!fin_q) begin
              state_q <= S_IDLE;
            end else if (!padded_q) begin
              state_q <= S_PAD;
            end else begin
              state_q <= S_SUM_START;
            end
          end
        end
        S_SUM_START: state_q <= S_SUM_WAIT;
        S_SUM_WAIT: begin
          if (stat.done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_q       <= digest;
            out_valid_q <= 1'b1;
            fin_q       <= 1'b0;
            padded_q    <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/md2_chk.sv
// md2_chk: port-level checks on md2_hash_engine, attached by bind
// depends on md2_pkg and md2_hash_engine
`timescale 1ns / 1ps
`default_nettype none

module md2_chk (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_o,
  input md2_pkg::md2_in_t  in_data_i,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input md2_pkg::md2_out_t out_data_o
);
  import md2_pkg::*;

  // held digest beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("digest beat dropped or changed while stalled");

  // a digest only appears after a busy cycle
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("digest appeared without compression");

  // a finishing beat always starts compression work
  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode != MODE_ABSORB) |=> !in_ready_o)
    else $error("finishing beat did not start work");

  // no digest right after a finishing beat
  a_fin_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode != MODE_ABSORB) |=> !$rose(out_valid_o))
    else $error("digest appeared too early");

endmodule

bind md2_hash_engine md2_chk u_md2_chk (.*);

`default_nettype wire
